[rtl/pvci_pkg.sv]
// Shared types and constants of the pixel value to colour index mapper.
package pvci_pkg;

	typedef enum logic [2:0] {
		REG_BOUND_A = 3'd0,
		REG_BOUND_B = 3'd1,
		REG_INDEX_A = 3'd2,
		REG_INDEX_B = 3'd3,
		REG_MODE    = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		MODE_LINEAR = 2'd0,
		MODE_LOG    = 2'd1,
		MODE_SQRT   = 2'd2
	} mode_t;

	localparam int unsigned LOG_SCALE  = 65000;
	localparam int unsigned LOG_HEAD   = 16;
	localparam int unsigned LOG_INT_W  = 5;
	localparam int unsigned LOG_FRAC_W = 32;
	localparam int unsigned LOG_W      = LOG_INT_W + LOG_FRAC_W;

	function automatic logic [LOG_W-1:0] log2_of_full_scale();
		logic [63:0] m;
		logic [LOG_FRAC_W-1:0] fr;
		m  = 64'd65001 << 16;
		fr = '0;
		for (int i = 0; i < LOG_FRAC_W; i++) begin
			m  = (m * m) >> 31;
			fr = {fr[LOG_FRAC_W-2:0], 1'b0};
			if (m[32]) begin
				m     = m >> 1;
				fr[0] = 1'b1;
			end
		end
		return {5'd15, fr};
	endfunction

	localparam logic [LOG_W-1:0] LOG_MAX = log2_of_full_scale();

endpackage

[rtl/pvci_if.sv]
// Stream channel interfaces for pixel values and colour indices.
interface pvci_pixel_if #(parameter int unsigned W = 32);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] pixel_value;
	modport source(output valid, output pixel_value, input ready);
	modport sink(input valid, input pixel_value, output ready);
endinterface

interface pvci_color_if #(parameter int unsigned W = 16);
	logic         valid;
	logic         ready;
	logic [W-1:0] color_index;
	modport source(output valid, output color_index, input ready);
	modport sink(input valid, input color_index, output ready);
endinterface

[rtl/pvci_div.sv]
// Pipelined restoring fraction divider, one quotient bit per stage.
module pvci_div #(
	parameter int unsigned NUM_W  = 32,
	parameter int unsigned STEPS  = 24,
	parameter int unsigned SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [NUM_W-1:0]  num,
	input  logic [NUM_W-1:0]  den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [STEPS:0]    q,
	output logic [SIDE_W-1:0] out_side
);

	logic [STEPS:0]      v_s;
	logic [NUM_W-1:0]    r_s    [0:STEPS];
	logic [STEPS-1:0]    q_s    [0:STEPS];
	logic                sat_s  [0:STEPS];
	logic [SIDE_W-1:0]   side_s [0:STEPS];
	logic [NUM_W:0]      r2     [1:STEPS];
	logic [NUM_W-1:0]    r_nx   [1:STEPS];
	logic [STEPS:1]      ge;

	always_comb begin
		for (int k = 1; k <= STEPS; k++) begin
			r2[k]   = {r_s[k-1], 1'b0};
			ge[k]   = r2[k] >= {1'b0, den};
			r_nx[k] = ge[k] ? NUM_W'(r2[k] - {1'b0, den}) : r2[k][NUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0]    <= num;
			q_s[0]    <= '0;
			sat_s[0]  <= num >= den;
			side_s[0] <= in_side;
			for (int k = 1; k <= STEPS; k++) begin
				r_s[k]    <= r_nx[k];
				q_s[k]    <= {q_s[k-1][STEPS-2:0], ge[k]};
				sat_s[k]  <= sat_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign q         = sat_s[STEPS] ? {1'b1, {STEPS{1'b0}}} : {1'b0, q_s[STEPS]};
	assign out_side  = side_s[STEPS];

endmodule

[rtl/pvci_sqrt.sv]
// Pipelined digit-by-digit square root of a fraction, one root bit per stage.
module pvci_sqrt #(
	parameter int unsigned FB     = 24,
	parameter int unsigned SIDE_W = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [FB-1:0]     f,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [FB-1:0]     root,
	output logic [SIDE_W-1:0] out_side
);

	logic [FB:0]         v_s;
	logic [FB:0]         rem_s  [0:FB];
	logic [FB-1:0]       root_s [0:FB];
	logic [2*FB-1:0]     rad_s  [0:FB];
	logic [SIDE_W-1:0]   side_s [0:FB];
	logic [FB+2:0]       rem2   [1:FB];
	logic [FB+2:0]       trial  [1:FB];
	logic [FB:1]         ge;

	always_comb begin
		for (int k = 1; k <= FB; k++) begin
			rem2[k]  = {rem_s[k-1], rad_s[k-1][2*FB-1 -: 2]};
			trial[k] = {1'b0, root_s[k-1], 2'b01};
			ge[k]    = rem2[k] >= trial[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[FB-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= '0;
			root_s[0] <= '0;
			rad_s[0]  <= {f, {FB{1'b0}}};
			side_s[0] <= in_side;
			for (int k = 1; k <= FB; k++) begin
				rem_s[k]  <= ge[k] ? (FB+1)'(rem2[k] - trial[k]) : rem2[k][FB:0];
				root_s[k] <= {root_s[k-1][FB-2:0], ge[k]};
				rad_s[k]  <= {rad_s[k-1][2*FB-3:0], 2'b00};
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[FB];
	assign root      = root_s[FB];
	assign out_side  = side_s[FB];

endmodule

[rtl/pvci_log2.sv]
// Pipelined fixed-point log2: leading-one search, normalise, 32 squaring stages.
module pvci_log2 #(
	parameter int unsigned FB     = 24,
	parameter int unsigned SIDE_W = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [FB+pvci_pkg::LOG_HEAD-1:0] x,
	input  logic [SIDE_W-1:0]             in_side,
	output logic                          out_valid,
	output logic [pvci_pkg::LOG_W-1:0]    lx,
	output logic [SIDE_W-1:0]             out_side
);

	localparam int unsigned XW  = FB + pvci_pkg::LOG_HEAD;
	localparam int unsigned NW  = (XW > 32) ? XW : 32;
	localparam int unsigned P_W = $clog2(NW);
	localparam int unsigned FW  = pvci_pkg::LOG_FRAC_W;
	localparam int unsigned IW  = pvci_pkg::LOG_INT_W;

	logic [P_W-1:0]    p_c;
	logic              v_s1;
	logic [XW-1:0]     x_s1;
	logic [P_W-1:0]    p_s1;
	logic [SIDE_W-1:0] side_s1;
	logic [NW-1:0]     xn;
	logic [FW:0]       v_s;
	logic [31:0]       m_s    [0:FW];
	logic [FW-1:0]     fr_s   [0:FW];
	logic [IW-1:0]     ip_s   [0:FW];
	logic [SIDE_W-1:0] side_s [0:FW];
	logic [63:0]       sq     [1:FW];

	always_comb begin
		p_c = '0;
		for (int i = 0; i < XW; i++) begin
			if (x[i]) begin
				p_c = P_W'(i);
			end
		end
	end

	assign xn = NW'(x_s1) << (P_W'(NW - 1) - p_s1);

	always_comb begin
		for (int k = 1; k <= FW; k++) begin
			sq[k] = {32'd0, m_s[k-1]} * {32'd0, m_s[k-1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s  <= '0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s  <= {v_s[FW-1:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1      <= x;
			p_s1      <= p_c;
			side_s1   <= in_side;
			m_s[0]    <= xn[NW-1 -: 32];
			fr_s[0]   <= '0;
			ip_s[0]   <= IW'(p_s1 - P_W'(FB));
			side_s[0] <= side_s1;
			for (int k = 1; k <= FW; k++) begin
				m_s[k]    <= sq[k][63] ? sq[k][63:32] : sq[k][62:31];
				fr_s[k]   <= {fr_s[k-1][FW-2:0], sq[k][63]};
				ip_s[k]   <= ip_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign out_valid = v_s[FW];
	assign lx        = {ip_s[FW], fr_s[FW]};
	assign out_side  = side_s[FW];

endmodule

[rtl/pixel_value_to_color_index.sv]
// Top level of the pixel value to colour index mapper.
// Maps a stream of signed pixel values onto colour indices between two configured
// indices, after clamping to two configured data bounds and shaping the fraction
// linearly, logarithmically or by square root.
// Channels: pixel_in carries one pixel_value per transaction, color_out one
// color_index per transaction; both use valid/ready. cfg_we writes cfg_data into
// the register selected by cfg_index in the same clock; write only while idle.
// Throughput: one transaction per clock while color_out does not stall. The pipeline
// runs through the two bit-per-stage dividers, the bit-per-stage square root and
// the 32 squaring stages of the log2 unit, all in line.
// Every item passes through every unit; the mode selects the result at the end.
// Reset clears all valid bits and loads the register defaults (bounds 0 and 65535,
// indices 0 and 255, linear mode).
// When color_out stalls, the whole pipeline holds and pixel_in.ready falls in
// the same cycle; nothing is dropped or repeated.
module pixel_value_to_color_index #(
	parameter int unsigned PIXEL_WIDTH   = 32,
	parameter int unsigned INDEX_WIDTH   = 16,
	parameter int unsigned FRACTION_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [((PIXEL_WIDTH > INDEX_WIDTH) ? PIXEL_WIDTH : INDEX_WIDTH)-1:0] cfg_data,
	pvci_pixel_if.sink            pixel_in,
	pvci_color_if.source          color_out
);

	localparam int unsigned PW  = PIXEL_WIDTH;
	localparam int unsigned IW  = INDEX_WIDTH;
	localparam int unsigned FB  = FRACTION_BITS;
	localparam int unsigned XW  = FB + pvci_pkg::LOG_HEAD;
	localparam int unsigned LW  = pvci_pkg::LOG_W;
	localparam int unsigned PRW = IW + FB + 1;
	localparam int unsigned SQ_SIDE = XW + FB + 1 + 2;
	localparam int unsigned LG_SIDE = FB + FB + 1 + 2;

	logic [PW-1:0] bound_a_q, bound_b_q;
	logic [IW-1:0] index_a_q, index_b_q;
	logic [1:0]    mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_a_q <= '0;
			bound_b_q <= PW'(65535);
			index_a_q <= '0;
			index_b_q <= IW'(255);
			mode_q    <= pvci_pkg::MODE_LINEAR;
		end else if (cfg_we) begin
			unique case (pvci_pkg::cfg_reg_t'(cfg_index))
				pvci_pkg::REG_BOUND_A: bound_a_q <= cfg_data[PW-1:0];
				pvci_pkg::REG_BOUND_B: bound_b_q <= cfg_data[PW-1:0];
				pvci_pkg::REG_INDEX_A: index_a_q <= cfg_data[IW-1:0];
				pvci_pkg::REG_INDEX_B: index_b_q <= cfg_data[IW-1:0];
				pvci_pkg::REG_MODE:    mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic [PW-1:0] sign_bit, ka, kb, lo, hi, den, kv, kc;
	logic [IW-1:0] ilo, span;
	logic          en;

	assign sign_bit = {1'b1, {(PW-1){1'b0}}};
	assign ka   = bound_a_q ^ sign_bit;
	assign kb   = bound_b_q ^ sign_bit;
	assign lo   = (ka < kb) ? ka : kb;
	assign hi   = (ka < kb) ? kb : ka;
	assign den  = (hi == lo) ? PW'(1) : hi - lo;
	assign ilo  = (index_a_q < index_b_q) ? index_a_q : index_b_q;
	assign span = (index_a_q < index_b_q) ? index_b_q - index_a_q : index_a_q - index_b_q;
	assign kv   = pixel_in.pixel_value ^ sign_bit;
	assign kc   = (kv < lo) ? lo : ((kv > hi) ? hi : kv);

	logic          out_valid_q;
	assign en             = !out_valid_q || color_out.ready;
	assign pixel_in.ready = en;

	// clamp, then offset from the smaller bound
	logic          v_s1, v_s2;
	logic [PW-1:0] kc_s1, num_s2;
	logic [1:0]    mode_s1, mode_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel_in.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kc_s1   <= kc;
			mode_s1 <= mode_q;
			num_s2  <= (hi == lo) ? '0 : kc_s1 - lo;
			mode_s2 <= mode_s1;
		end
	end

	logic          f_valid;
	logic [FB:0]   f;
	logic [1:0]    f_mode;

	pvci_div #(.NUM_W(PW), .STEPS(FB), .SIDE_W(2)) u_div_f (
		.clk, .arst_n, .en,
		.in_valid (v_s2),
		.num      (num_s2),
		.den      (den),
		.in_side  (mode_s2),
		.out_valid(f_valid),
		.q        (f),
		.out_side (f_mode)
	);

	// log argument 1 + 65000 f
	logic          v_s3;
	logic [XW-1:0] x_s3;
	logic [FB:0]   f_s3;
	logic [1:0]    mode_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s3    <= XW'(f) * XW'(pvci_pkg::LOG_SCALE) + {{(XW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
			f_s3    <= f;
			mode_s3 <= f_mode;
		end
	end

	logic               sq_valid;
	logic [FB-1:0]      root;
	logic [SQ_SIDE-1:0] sq_side;

	pvci_sqrt #(.FB(FB), .SIDE_W(SQ_SIDE)) u_sqrt (
		.clk, .arst_n, .en,
		.in_valid (v_s3),
		.f        (f_s3[FB-1:0]),
		.in_side  ({x_s3, f_s3, mode_s3}),
		.out_valid(sq_valid),
		.root     (root),
		.out_side (sq_side)
	);

	logic               lg_valid;
	logic [LW-1:0]      lx;
	logic [LG_SIDE-1:0] lg_side;

	pvci_log2 #(.FB(FB), .SIDE_W(LG_SIDE)) u_log2 (
		.clk, .arst_n, .en,
		.in_valid (sq_valid),
		.x        (sq_side[SQ_SIDE-1 -: XW]),
		.in_side  ({root, sq_side[FB+2:0]}),
		.out_valid(lg_valid),
		.lx       (lx),
		.out_side (lg_side)
	);

	logic               dg_valid;
	logic [FB:0]        gl;
	logic [LG_SIDE-1:0] dg_side;

	pvci_div #(.NUM_W(LW), .STEPS(FB), .SIDE_W(LG_SIDE)) u_div_g (
		.clk, .arst_n, .en,
		.in_valid (lg_valid),
		.num      (lx),
		.den      (pvci_pkg::LOG_MAX),
		.in_side  (lg_side),
		.out_valid(dg_valid),
		.q        (gl),
		.out_side (dg_side)
	);

	logic [FB-1:0] root_d;
	logic [FB:0]   f_d, g_c;
	logic [1:0]    mode_d;

	assign root_d = dg_side[LG_SIDE-1 -: FB];
	assign f_d    = dg_side[FB+2:2];
	assign mode_d = dg_side[1:0];

	always_comb begin
		case (mode_d)
			pvci_pkg::MODE_LINEAR: g_c = f_d;
			pvci_pkg::MODE_LOG:    g_c = gl;
			pvci_pkg::MODE_SQRT:   g_c = f_d[FB] ? {1'b1, {FB{1'b0}}} : {1'b0, root_d};
			default:               g_c = '0;
		endcase
	end

	// select, scale by the index span, round and offset
	logic           v_s4, v_s5;
	logic [FB:0]    g_s4;
	logic [PRW-1:0] prod_s5;
	logic [IW-1:0]  color_index_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s4        <= dg_valid;
			v_s5        <= v_s4;
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s4           <= g_c;
			prod_s5        <= PRW'(span) * PRW'(g_s4);
			color_index_s6 <= ilo + IW'((prod_s5 + PRW'({1'b1, {(FB-1){1'b0}}})) >> FB);
		end
	end

	assign color_out.valid       = out_valid_q;
	assign color_out.color_index = color_index_s6;

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		color_out.valid |-> (color_out.color_index >= ilo) &&
			({1'b0, color_out.color_index} <= {1'b0, ilo} + {1'b0, span}))
		else $error("colour index outside the configured index range");

	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(color_out.valid && mode_q != pvci_pkg::MODE_LINEAR && mode_q != pvci_pkg::MODE_LOG &&
			mode_q != pvci_pkg::MODE_SQRT) |-> color_out.color_index == ilo)
		else $error("unused mode did not give the smaller index");

	a_equal_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(color_out.valid && lo == hi) |-> color_out.color_index == ilo)
		else $error("equal bounds did not give the smaller index");

endmodule
